/* design/tdyr_pkg.sv */
package tdyr_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W = 13;
  localparam int CNT_W = 12;
  localparam int PIX_W = 8;
  localparam int COEF_FRAC_BITS = 16;

  localparam int COEF_W = 18;
  localparam int PROD_W = 26;
  localparam int ACC_W = 27;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  localparam longint COEF_ONE = longint'(1) << COEF_FRAC_BITS;
  localparam longint K_RED_L = (1402 * COEF_ONE + 500) / 1000;
  localparam longint K_GREEN_B_L = (34414 * COEF_ONE + 50000) / 100000;
  localparam longint K_GREEN_R_L = (71414 * COEF_ONE + 50000) / 100000;
  localparam longint K_BLUE_L = (1772 * COEF_ONE + 500) / 1000;

  localparam logic signed [COEF_W-1:0] K_RED = COEF_W'(K_RED_L);
  localparam logic signed [COEF_W-1:0] K_GREEN_B = COEF_W'(K_GREEN_B_L);
  localparam logic signed [COEF_W-1:0] K_GREEN_R = COEF_W'(K_GREEN_R_L);
  localparam logic signed [COEF_W-1:0] K_BLUE = COEF_W'(K_BLUE_L);

  localparam logic [DIM_W-1:0] RST_SRC_WIDTH = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_COL_STEP = DIM_W'(1);
  localparam logic [DIM_W-1:0] RST_ROW_STEP = DIM_W'(1);
  localparam logic [DIM_W-1:0] RST_THUMB_WIDTH = DIM_W'(60);
  localparam logic [DIM_W-1:0] RST_THUMB_HEIGHT = DIM_W'(40);

  typedef enum logic [2:0] {
    REG_SRC_WIDTH    = 3'd0,
    REG_COL_STEP     = 3'd1,
    REG_ROW_STEP     = 3'd2,
    REG_THUMB_WIDTH  = 3'd3,
    REG_THUMB_HEIGHT = 3'd4
  } tdyr_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0] src_width;
    logic [DIM_W-1:0] col_step;
    logic [DIM_W-1:0] row_step;
    logic [DIM_W-1:0] thumb_width;
    logic [DIM_W-1:0] thumb_height;
  } tdyr_cfg_t;

  // One kept pixel on its way to the color converter.
  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
    logic             last_pixel;
  } tdyr_job_t;

  function automatic logic [DIM_W-1:0] effective(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  // Negative sums go to zero; otherwise drop the fraction and saturate.
  function automatic logic [PIX_W-1:0] to_byte(input logic signed [ACC_W-1:0] acc);
    logic [PIX_W-1:0] r;
    if (acc[ACC_W-1]) r = '0;
    else if (acc[ACC_W-2:COEF_FRAC_BITS+PIX_W] != '0) r = '1;
    else r = acc[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
    return r;
  endfunction

endpackage

/* design/tdyr_if.sv */
interface tdyr_pix_if;
  logic                        valid;
  logic                        ready;
  logic                        frame_start;
  logic [tdyr_pkg::PIX_W-1:0]  luma;
  logic [tdyr_pkg::PIX_W-1:0]  chroma_blue;
  logic [tdyr_pkg::PIX_W-1:0]  chroma_red;

  modport source (output valid, frame_start, luma, chroma_blue, chroma_red, input ready);
  modport sink (input valid, frame_start, luma, chroma_blue, chroma_red, output ready);
endinterface

interface tdyr_rgb_if;
  logic                        valid;
  logic                        ready;
  logic [tdyr_pkg::PIX_W-1:0]  red;
  logic [tdyr_pkg::PIX_W-1:0]  green;
  logic [tdyr_pkg::PIX_W-1:0]  blue;
  logic                        last_pixel;

  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink (input valid, red, green, blue, last_pixel, output ready);
endinterface

/* design/thumbnail_decimate_yuv_to_rgb.sv */
// Thumbnail decimator with full-range BT.601 YCbCr to RGB conversion.
// pix_in takes one source pixel per item in raster order: luma, the chroma
// pair of its 2x2 block and a frame-start flag. rgb_out gives one item per
// kept pixel, with last_pixel set on the bottom-right pixel of the thumbnail.
// Source pixels that are dropped produce no item.
// Throughput is one source pixel per cycle unless the queue is full; the front
// classifies each pixel in the cycle it is accepted, and the converter is a
// two-stage pipeline. A kept pixel accepted on pix_in is written into the
// queue, then passes through the product and output registers to rgb_out.
// When rgb_out stalls, the converter holds and a four-entry queue between
// the counters and the converter absorbs kept pixels; pix_in.ready falls only
// when that queue is full.
// Registers sit on an APB port at byte addresses 0, 4, 8, 12 and 16:
// src_width, col_step, row_step, thumb_width, thumb_height. Zero acts as one
// and values above 4096 as 4096. Change them only while the block is idle.
// Reset clears all counters, empties the queue and pipeline and loads the
// registers with 640, 1, 1, 60 and 40.
module thumbnail_decimate_yuv_to_rgb (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tdyr_pix_if.sink                          pix_in,
  tdyr_rgb_if.source                        rgb_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tdyr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tdyr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tdyr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  tdyr_pkg::tdyr_cfg_t cfg_q;
  tdyr_pkg::tdyr_job_t push_job, head_job;
  tdyr_pkg::tdyr_reg_e reg_sel;
  logic                push, full, head_valid, pop;
  logic [tdyr_pkg::DIM_W-1:0] wval, rval;

  assign pready = 1'b1;
  assign reg_sel = tdyr_pkg::tdyr_reg_e'(paddr[tdyr_pkg::CFG_ADDR_W-1:2]);
  assign wval = pwdata[tdyr_pkg::DIM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width <= tdyr_pkg::RST_SRC_WIDTH;
      cfg_q.col_step <= tdyr_pkg::RST_COL_STEP;
      cfg_q.row_step <= tdyr_pkg::RST_ROW_STEP;
      cfg_q.thumb_width <= tdyr_pkg::RST_THUMB_WIDTH;
      cfg_q.thumb_height <= tdyr_pkg::RST_THUMB_HEIGHT;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        tdyr_pkg::REG_SRC_WIDTH: cfg_q.src_width <= wval;
        tdyr_pkg::REG_COL_STEP: cfg_q.col_step <= wval;
        tdyr_pkg::REG_ROW_STEP: cfg_q.row_step <= wval;
        tdyr_pkg::REG_THUMB_WIDTH: cfg_q.thumb_width <= wval;
        tdyr_pkg::REG_THUMB_HEIGHT: cfg_q.thumb_height <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tdyr_pkg::REG_SRC_WIDTH: rval = cfg_q.src_width;
      tdyr_pkg::REG_COL_STEP: rval = cfg_q.col_step;
      tdyr_pkg::REG_ROW_STEP: rval = cfg_q.row_step;
      tdyr_pkg::REG_THUMB_WIDTH: rval = cfg_q.thumb_width;
      tdyr_pkg::REG_THUMB_HEIGHT: rval = cfg_q.thumb_height;
      default: rval = '0;
    endcase
    prdata = tdyr_pkg::CFG_DATA_W'(rval);
  end

  tdyr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .pix_in (pix_in),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  tdyr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head_job)
  );

  tdyr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .job_i   (head_job),
    .pop_o   (pop),
    .rgb_out (rgb_out)
  );

endmodule

/* design/tdyr_front.sv */
module tdyr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tdyr_pkg::tdyr_cfg_t cfg_i,
  tdyr_pix_if.sink            pix_in,
  input  logic                full_i,
  output logic                push_o,
  output tdyr_pkg::tdyr_job_t job_o
);

  logic [tdyr_pkg::CNT_W-1:0] scol_q, scol_d, cphase_q, cphase_d, rphase_q, rphase_d;
  logic [tdyr_pkg::DIM_W-1:0] ocol_q, ocol_d, orow_q, orow_d;

  logic [tdyr_pkg::DIM_W-1:0] sw, cs, rs, tw, th;
  logic [tdyr_pkg::CNT_W-1:0] scol0, cphase0, rphase0, scol1, cphase1, rphase1;
  logic [tdyr_pkg::DIM_W-1:0] ocol0, orow0, ocol1;
  logic [tdyr_pkg::DIM_W-1:0] scol_inc, cphase_inc, rphase_inc;
  logic                       accept, row_kept, keep;

  assign sw = tdyr_pkg::effective(cfg_i.src_width);
  assign cs = tdyr_pkg::effective(cfg_i.col_step);
  assign rs = tdyr_pkg::effective(cfg_i.row_step);
  assign tw = tdyr_pkg::effective(cfg_i.thumb_width);
  assign th = tdyr_pkg::effective(cfg_i.thumb_height);

  assign pix_in.ready = !full_i;
  assign accept = pix_in.valid && !full_i;

  always_comb begin
    if (pix_in.frame_start) begin
      scol0 = '0;
      cphase0 = '0;
      rphase0 = '0;
      ocol0 = '0;
      orow0 = '0;
    end else begin
      scol0 = scol_q;
      cphase0 = cphase_q;
      rphase0 = rphase_q;
      ocol0 = ocol_q;
      orow0 = orow_q;
    end

    // Pull the counters back into range in case the registers shrank.
    if ({1'b0, scol0} >= sw) scol1 = tdyr_pkg::CNT_W'(sw - 1'b1);
    else scol1 = scol0;
    if ({1'b0, cphase0} >= cs) cphase1 = '0;
    else cphase1 = cphase0;
    if ({1'b0, rphase0} >= rs) rphase1 = '0;
    else rphase1 = rphase0;

    row_kept = (rphase1 == '0) && (orow0 < th);
    keep = row_kept && (cphase1 == '0) && (ocol0 < tw);
    ocol1 = keep ? ocol0 + 1'b1 : ocol0;

    scol_inc = {1'b0, scol1} + 1'b1;
    cphase_inc = {1'b0, cphase1} + 1'b1;
    rphase_inc = {1'b0, rphase1} + 1'b1;

    if (scol_inc >= sw) begin
      scol_d = '0;
      cphase_d = '0;
      ocol_d = '0;
      orow_d = (row_kept && ocol1 != '0) ? orow0 + 1'b1 : orow0;
      rphase_d = (rphase_inc >= rs) ? '0 : rphase_inc[tdyr_pkg::CNT_W-1:0];
    end else begin
      scol_d = scol_inc[tdyr_pkg::CNT_W-1:0];
      cphase_d = (cphase_inc >= cs) ? '0 : cphase_inc[tdyr_pkg::CNT_W-1:0];
      ocol_d = ocol1;
      orow_d = orow0;
      rphase_d = rphase1;
    end
  end

  assign push_o = accept && keep;
  assign job_o.luma = pix_in.luma;
  assign job_o.chroma_blue = pix_in.chroma_blue;
  assign job_o.chroma_red = pix_in.chroma_red;
  assign job_o.last_pixel = (ocol0 == tw - 1'b1) && (orow0 == th - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scol_q <= '0;
      cphase_q <= '0;
      rphase_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (accept) begin
      scol_q <= scol_d;
      cphase_q <= cphase_d;
      rphase_q <= rphase_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
    end
  end

endmodule

/* design/tdyr_fifo.sv */
module tdyr_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tdyr_pkg::tdyr_job_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output tdyr_pkg::tdyr_job_t head_o
);

  tdyr_pkg::tdyr_job_t             slot_q [tdyr_pkg::FIFO_DEPTH];
  logic [tdyr_pkg::FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [tdyr_pkg::FIFO_PTR_W:0]   cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o = (cnt_q == (tdyr_pkg::FIFO_PTR_W+1)'(tdyr_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;

  always_comb begin
    wr_d = do_push ? wr_q + 1'b1 : wr_q;
    rd_d = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* design/tdyr_back.sv */
module tdyr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  tdyr_pkg::tdyr_job_t job_i,
  output logic                pop_o,
  tdyr_rgb_if.source          rgb_out
);

  logic                                   adv;
  logic                                   s1_v_q, out_v_q;
  logic signed [tdyr_pkg::PIX_W-1:0]      db, dr;
  logic signed [tdyr_pkg::PROD_W-1:0]     p_r_q, p_gb_q, p_gr_q, p_b_q;
  logic [tdyr_pkg::PIX_W-1:0]             y_q;
  logic                                   last_q;
  logic signed [tdyr_pkg::ACC_W-1:0]      base, acc_r, acc_g, acc_b;
  logic [tdyr_pkg::PIX_W-1:0]             red_q, green_q, blue_q;
  logic                                   out_last_q;

  // The pipeline moves whenever the output register is empty or being taken.
  assign adv = !out_v_q || rgb_out.ready;
  assign pop_o = adv && valid_i;

  // Flipping the top bit of an unsigned sample gives sample - 128.
  assign db = $signed({~job_i.chroma_blue[tdyr_pkg::PIX_W-1],
                       job_i.chroma_blue[tdyr_pkg::PIX_W-2:0]});
  assign dr = $signed({~job_i.chroma_red[tdyr_pkg::PIX_W-1],
                       job_i.chroma_red[tdyr_pkg::PIX_W-2:0]});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_r_q <= tdyr_pkg::PROD_W'(dr) * tdyr_pkg::K_RED;
      p_gb_q <= tdyr_pkg::PROD_W'(db) * tdyr_pkg::K_GREEN_B;
      p_gr_q <= tdyr_pkg::PROD_W'(dr) * tdyr_pkg::K_GREEN_R;
      p_b_q <= tdyr_pkg::PROD_W'(db) * tdyr_pkg::K_BLUE;
      y_q <= job_i.luma;
      last_q <= job_i.last_pixel;
    end
  end

  always_comb begin
    base = $signed({{(tdyr_pkg::ACC_W-tdyr_pkg::PIX_W-tdyr_pkg::COEF_FRAC_BITS){1'b0}},
                    y_q, {tdyr_pkg::COEF_FRAC_BITS{1'b0}}});
    acc_r = base + tdyr_pkg::ACC_W'(p_r_q);
    acc_g = base - tdyr_pkg::ACC_W'(p_gb_q) - tdyr_pkg::ACC_W'(p_gr_q);
    acc_b = base + tdyr_pkg::ACC_W'(p_b_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q <= tdyr_pkg::to_byte(acc_r);
      green_q <= tdyr_pkg::to_byte(acc_g);
      blue_q <= tdyr_pkg::to_byte(acc_b);
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= valid_i;
      out_v_q <= s1_v_q;
    end
  end

  assign rgb_out.valid = out_v_q;
  assign rgb_out.red = red_q;
  assign rgb_out.green = green_q;
  assign rgb_out.blue = blue_q;
  assign rgb_out.last_pixel = out_last_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int FRAC_Q = 16;
  localparam longint ONE_Q = longint'(1) << FRAC_Q;
  localparam longint KR_Q = (1402 * ONE_Q + 500) / 1000;
  localparam longint KGB_Q = (34414 * ONE_Q + 50000) / 100000;
  localparam longint KGR_Q = (71414 * ONE_Q + 50000) / 100000;
  localparam longint KB_Q = (1772 * ONE_Q + 500) / 1000;
  localparam int unsigned DIM_LIMIT = 4096;

  localparam int TOTAL_ITEMS = 1300;
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD = 40;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic                       frame_start;
    logic [tdyr_pkg::PIX_W-1:0] luma;
    logic [tdyr_pkg::PIX_W-1:0] chroma_blue;
    logic [tdyr_pkg::PIX_W-1:0] chroma_red;
  } src_pix_t;

  typedef struct packed {
    logic [tdyr_pkg::PIX_W-1:0] red;
    logic [tdyr_pkg::PIX_W-1:0] green;
    logic [tdyr_pkg::PIX_W-1:0] blue;
    logic                       last_pixel;
  } rgb_pix_t;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    tdyr_pkg::tdyr_reg_e        reg_id;
    logic [tdyr_pkg::DIM_W-1:0] value;
    src_pix_t                   px;
    logic                       typed;
    rgb_pix_t                   want;
  } dir_row_t;

  localparam src_pix_t NO_PIX = '0;
  localparam rgb_pix_t NO_RGB = '0;

  // Extremes and gray pixels under the reset setting, then a 5-wide source
  // kept every second column into a 2x2 thumbnail: row end, the last pixel,
  // a full thumbnail, a height raised mid-frame and a step above the limit.
  localparam dir_row_t DIRECTED [30] = '{
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b1, 8'd128, 8'd128, 8'd128}, 1'b1,
      '{8'd128, 8'd128, 8'd128, 1'b0}},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd0, 8'd128, 8'd128}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd255, 8'd128, 8'd128}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 1'b0}},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd0, 8'd0, 8'd0}, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd255, 8'd255, 8'd255}, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd0, 8'd255, 8'd0}, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd255, 8'd0, 8'd255}, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'hAA, 8'h55, 8'hAA}, 1'b0, NO_RGB},
    '{ROW_CFG, tdyr_pkg::REG_SRC_WIDTH, 13'd5, NO_PIX, 1'b0, NO_RGB},
    '{ROW_CFG, tdyr_pkg::REG_COL_STEP, 13'd2, NO_PIX, 1'b0, NO_RGB},
    '{ROW_CFG, tdyr_pkg::REG_ROW_STEP, 13'd0, NO_PIX, 1'b0, NO_RGB},
    '{ROW_CFG, tdyr_pkg::REG_THUMB_WIDTH, 13'd2, NO_PIX, 1'b0, NO_RGB},
    '{ROW_CFG, tdyr_pkg::REG_THUMB_HEIGHT, 13'd2, NO_PIX, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b1, 8'd50, 8'd128, 8'd128}, 1'b1,
      '{8'd50, 8'd50, 8'd50, 1'b0}},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'h55, 8'hAA, 8'h55}, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd200, 8'd30, 8'd220}, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd1, 8'd2, 8'd3}, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd99, 8'd99, 8'd99}, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd10, 8'd240, 8'd20}, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd33, 8'd66, 8'd99}, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd77, 8'd128, 8'd128}, 1'b1,
      '{8'd77, 8'd77, 8'd77, 1'b1}},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd4, 8'd5, 8'd6}, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd7, 8'd8, 8'd9}, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd250, 8'd5, 8'd250}, 1'b0, NO_RGB},
    '{ROW_CFG, tdyr_pkg::REG_THUMB_HEIGHT, 13'd3, NO_PIX, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd60, 8'd70, 8'd80}, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd255, 8'd128, 8'd128}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 1'b0}},
    '{ROW_CFG, tdyr_pkg::REG_COL_STEP, 13'd8191, NO_PIX, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b1, 8'd120, 8'd200, 8'd40}, 1'b0, NO_RGB},
    '{ROW_PIX, tdyr_pkg::REG_SRC_WIDTH, 13'd0, '{1'b0, 8'd140, 8'd20, 8'd230}, 1'b0, NO_RGB}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel;
  logic penable;
  logic pwrite;
  logic [tdyr_pkg::CFG_ADDR_W-1:0] paddr;
  logic [tdyr_pkg::CFG_DATA_W-1:0] pwdata;
  logic [tdyr_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  tdyr_pix_if pix_if ();
  tdyr_rgb_if rgb_if ();

  thumbnail_decimate_yuv_to_rgb u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_in  (pix_if),
    .rgb_out (rgb_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Register mirror and decimation counters of the predictor.
  logic [tdyr_pkg::DIM_W-1:0] cfg_val [5] = '{13'd640, 13'd1, 13'd1, 13'd60, 13'd40};
  int unsigned col_count = 0;
  int unsigned col_phase = 0;
  int unsigned row_phase = 0;
  int unsigned kept_in_row = 0;
  int unsigned kept_rows = 0;

  rgb_pix_t expected_rgb_q [$];
  rgb_pix_t rgb_want;

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned last_marks = 0;
  int unsigned regs_written = 0;
  int unsigned error_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;

  function automatic int unsigned clip_dim(logic [tdyr_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return 32'(v);
  endfunction

  function automatic logic [tdyr_pkg::PIX_W-1:0] to_pixel(longint acc);
    longint v;
    if (acc < 0) return '0;
    v = acc >>> FRAC_Q;
    if (v > 255) return '1;
    return 8'(v);
  endfunction

  function automatic bit decimate_and_convert(input src_pix_t px, output rgb_pix_t res);
    int unsigned sw, cs, rs, tw, th;
    bit row_kept, keep;
    longint base, db, dr;
    sw = clip_dim(cfg_val[tdyr_pkg::REG_SRC_WIDTH]);
    cs = clip_dim(cfg_val[tdyr_pkg::REG_COL_STEP]);
    rs = clip_dim(cfg_val[tdyr_pkg::REG_ROW_STEP]);
    tw = clip_dim(cfg_val[tdyr_pkg::REG_THUMB_WIDTH]);
    th = clip_dim(cfg_val[tdyr_pkg::REG_THUMB_HEIGHT]);
    res = '0;
    if (px.frame_start) begin
      col_count = 0;
      col_phase = 0;
      row_phase = 0;
      kept_in_row = 0;
      kept_rows = 0;
    end
    // Registers may have shrunk since the counters last moved.
    if (col_count >= sw) col_count = sw - 1;
    if (col_phase >= cs) col_phase = 0;
    if (row_phase >= rs) row_phase = 0;
    row_kept = (row_phase == 0) && (kept_rows < th);
    keep = row_kept && (col_phase == 0) && (kept_in_row < tw);
    if (keep) begin
      base = longint'(px.luma) <<< FRAC_Q;
      db = longint'(px.chroma_blue) - 128;
      dr = longint'(px.chroma_red) - 128;
      res.red = to_pixel(base + KR_Q * dr);
      res.green = to_pixel(base - KGB_Q * db - KGR_Q * dr);
      res.blue = to_pixel(base + KB_Q * db);
      res.last_pixel = (kept_in_row == tw - 1) && (kept_rows == th - 1);
      kept_in_row++;
    end
    if (col_count + 1 >= sw) begin
      if (row_kept && kept_in_row > 0) kept_rows++;
      col_count = 0;
      col_phase = 0;
      kept_in_row = 0;
      row_phase = (row_phase + 1 >= rs) ? 0 : row_phase + 1;
    end else begin
      col_count++;
      col_phase = (col_phase + 1 >= cs) ? 0 : col_phase + 1;
    end
    return keep;
  endfunction

  function automatic logic [tdyr_pkg::PIX_W-1:0] pick_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [tdyr_pkg::DIM_W-1:0] pick_dim(int unsigned hi);
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return tdyr_pkg::DIM_W'(DIM_LIMIT);
    if (pick == 2) return tdyr_pkg::DIM_W'(DIM_LIMIT + 1);
    if (pick == 3) return '1;
    return tdyr_pkg::DIM_W'($urandom_range(1, hi));
  endfunction

  function automatic int unsigned pick_idle_pct();
    int unsigned pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) return 0;
    if (pick == 1) return 15;
    return 35;
  endfunction

  function automatic src_pix_t random_pixel(logic fs);
    src_pix_t px;
    px.frame_start = fs;
    px.luma = pick_sample();
    px.chroma_blue = pick_sample();
    px.chroma_red = pick_sample();
    return px;
  endfunction

  function automatic void check_field(string name, logic [tdyr_pkg::PIX_W-1:0] want,
                                      logic [tdyr_pkg::PIX_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic send_pixel(input src_pix_t px, input logic typed, input rgb_pix_t typed_rgb);
    rgb_pix_t predicted;
    int unsigned gap;
    if (!no_idle && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      pix_if.valid = 1'b0;
      gap = $urandom_range(0, 2);
      repeat (gap) @(negedge clk_i);
    end
    @(negedge clk_i);
    pix_if.valid = 1'b1;
    pix_if.frame_start = px.frame_start;
    pix_if.luma = px.luma;
    pix_if.chroma_blue = px.chroma_blue;
    pix_if.chroma_red = px.chroma_red;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    items_sent++;
    if (decimate_and_convert(px, predicted)) begin
      expected_rgb_q.push_back(typed ? typed_rgb : predicted);
    end
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    pix_if.valid = 1'b0;
    while (expected_rgb_q.size() != 0) @(posedge clk_i);
  endtask

  // Dropped pixels leave nothing to wait for, so allow the pipeline to empty.
  task automatic wait_block_idle();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input tdyr_pkg::tdyr_reg_e idx,
                           input logic [tdyr_pkg::DIM_W-1:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = tdyr_pkg::CFG_ADDR_W'(int'(idx) * 4);
    pwdata = tdyr_pkg::CFG_DATA_W'(val);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cfg_val[idx] = val;
    regs_written++;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic program_setting(input logic [tdyr_pkg::DIM_W-1:0] sw, cs, rs, tw, th);
    apb_write(tdyr_pkg::REG_SRC_WIDTH, sw);
    apb_write(tdyr_pkg::REG_COL_STEP, cs);
    apb_write(tdyr_pkg::REG_ROW_STEP, rs);
    apb_write(tdyr_pkg::REG_THUMB_WIDTH, tw);
    apb_write(tdyr_pkg::REG_THUMB_HEIGHT, th);
  endtask

  // Frames of up to 100 pixels, never past every kept row plus one extra row,
  // some cut shorter, some with no frame start, and a stray frame start at times.
  task automatic run_random_phase(input int unsigned n_items);
    longint full_len;
    int unsigned frame_left, sw, rs, th;
    logic fs;
    frame_left = 0;
    repeat (n_items) begin
      if (frame_left == 0) begin
        sw = clip_dim(cfg_val[tdyr_pkg::REG_SRC_WIDTH]);
        rs = clip_dim(cfg_val[tdyr_pkg::REG_ROW_STEP]);
        th = clip_dim(cfg_val[tdyr_pkg::REG_THUMB_HEIGHT]);
        full_len = longint'(sw) * rs * th + sw;
        frame_left = $urandom_range(8, 100);
        if (full_len < frame_left) frame_left = 32'(full_len);
        if ($urandom_range(0, 7) == 0) frame_left = $urandom_range(1, frame_left);
        if ($urandom_range(0, 5) == 0) wait_results_drained();
        fs = ($urandom_range(0, 9) != 0);
      end else begin
        fs = ($urandom_range(0, 49) == 0);
      end
      send_pixel(random_pixel(fs), 1'b0, NO_RGB);
      frame_left--;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rgb_if.valid && rgb_if.ready) begin
      results_seen++;
      if (rgb_if.last_pixel === 1'b1) last_marks++;
      if (expected_rgb_q.size() == 0) begin
        error_count++;
        $display("%0t: RGB item with none expected, actual r=%0d g=%0d b=%0d last=%0d",
                 $time, rgb_if.red, rgb_if.green, rgb_if.blue, rgb_if.last_pixel);
      end else begin
        rgb_want = expected_rgb_q.pop_front();
        check_field("red", rgb_want.red, rgb_if.red);
        check_field("green", rgb_want.green, rgb_if.green);
        check_field("blue", rgb_want.blue, rgb_if.blue);
        check_field("last_pixel", tdyr_pkg::PIX_W'(rgb_want.last_pixel),
                    tdyr_pkg::PIX_W'(rgb_if.last_pixel));
      end
    end
  end

  initial begin : rgb_receiver
    int unsigned stall;
    rgb_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        rgb_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_request = 1'b0;
      end else if (!no_idle && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        rgb_if.ready = 1'b0;
        stall = $urandom_range(0, 2);
        repeat (stall) @(negedge clk_i);
      end else begin
        rgb_if.ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (pix_if.valid && pix_if.ready) || (rgb_if.valid && rgb_if.ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("tb_top: no item moved for %0d cycles, %0d results outstanding",
             STALL_LIMIT, expected_rgb_q.size());
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_no;
    pix_if.valid = 1'b0;
    pix_if.frame_start = 1'b0;
    pix_if.luma = '0;
    pix_if.chroma_blue = '0;
    pix_if.chroma_red = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    idle_pct = 20;
    stall_pct = 20;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_block_idle();
        apb_write(DIRECTED[i].reg_id, DIRECTED[i].value);
      end else begin
        send_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    phase_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      wait_block_idle();
      no_idle = (items_sent + QUIET_TAIL >= TOTAL_ITEMS);
      idle_pct = no_idle ? 0 : pick_idle_pct();
      stall_pct = no_idle ? 0 : pick_idle_pct();
      case (phase_no)
        0: begin
          program_setting('0, '0, '0, '0, '0);
          run_random_phase($urandom_range(60, 110));
        end
        1: begin
          program_setting(tdyr_pkg::DIM_W'(DIM_LIMIT), tdyr_pkg::DIM_W'(DIM_LIMIT),
                          tdyr_pkg::DIM_W'(DIM_LIMIT), tdyr_pkg::DIM_W'(DIM_LIMIT),
                          tdyr_pkg::DIM_W'(DIM_LIMIT));
          run_random_phase($urandom_range(60, 110));
        end
        2: begin
          program_setting('1, '1, '1, '1, '1);
          run_random_phase($urandom_range(60, 110));
        end
        3: begin
          // Every pixel kept while the receiver holds off: the input must stall.
          program_setting(13'd8, 13'd1, 13'd1, 13'd8, 13'd8);
          idle_pct = 0;
          @(posedge clk_i);
          hold_request = 1'b1;
          for (int k = 0; k < 72; k++) begin
            send_pixel(random_pixel(k == 0), 1'b0, NO_RGB);
          end
          wait_results_drained();
        end
        default: begin
          program_setting(pick_dim(12), pick_dim(4), pick_dim(3), pick_dim(6), pick_dim(5));
          run_random_phase($urandom_range(60, 110));
        end
      endcase
      phase_no++;
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("tb_top: %0d source pixels sent, %0d RGB items checked, %0d of them frame-final",
             items_sent, results_seen, last_marks);
    $display("tb_top: %0d register writes over %0d settings, zero and out-of-range included",
             regs_written, phase_no + 1);
    if (error_count == 0 && expected_rgb_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/tdyr_pkg.sv
design/tdyr_if.sv
design/tdyr_front.sv
design/tdyr_fifo.sv
design/tdyr_back.sv
design/thumbnail_decimate_yuv_to_rgb.sv
tb/tb_top.sv
